### rtl/swrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swrs_pkg;

    localparam int DRAW_W     = 15;
    localparam int DRAW_CNT_W = 4;
    localparam int VALUE_W    = 32;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CONFLICT = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_RM_READ,
        ST_RM_WRITE,
        ST_DIVIDE,
        ST_SAMPLE_READ,
        ST_SAMPLE_DATA,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    start;
        logic    scan;
        logic    div_step;
        logic    rd_last;
        logic    write_insert;
        logic    write_move;
        logic    rd_sample;
        logic    capture_sample;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  match;
        logic  miss;
        logic  count_zero;
        logic  count_full;
        logic  div_done;
        logic  out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/swrs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module swrs_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire swrs_pkg::ctrl_cmd_t              cmd,
    output swrs_pkg::dp_status_t                  stat,
    input  wire logic [1:0]                       mode,
    input  wire logic signed [31:0]               item_value,
    input  wire logic [swrs_pkg::DRAW_W-1:0]      random_draw,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            status,
    output logic signed [31:0]                    sampled_value
);
    import swrs_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] mem [CAPACITY];

    mode_t              mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_addr_reg;
    logic               chk_valid_reg;
    logic [IDX_W-1:0]   chk_addr_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [DRAW_CNT_W-1:0] bit_cnt_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    status_t            res_status_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic               issue;
    logic               match;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [CNT_W:0]     trial;
    logic               trial_ge;
    logic [CNT_W-1:0]   rem_next;
    logic               out_free;

    assign issue    = cmd.scan && (scan_addr_reg < count_reg);
    assign match    = chk_valid_reg && (rd_data_reg == value_reg);
    assign count_m1 = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.rd_last)
        begin
            rd_addr = count_m1[IDX_W-1:0];
        end
        else if (cmd.rd_sample)
        begin
            rd_addr = rem_reg[IDX_W-1:0];
        end
        else
        begin
            rd_addr = scan_addr_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = cmd.write_insert || cmd.write_move;
        wr_addr = cmd.write_move ? pos_reg : count_reg[IDX_W-1:0];
        wr_data = cmd.write_move ? rd_data_reg : value_reg;
    end

    // One restoring step of the remainder: bring down the next bit of the draw.
    always_comb
    begin
        trial    = {rem_reg, draw_reg[DRAW_W-1]};
        trial_ge = trial >= {1'b0, count_reg};
        if (trial_ge)
        begin
            rem_next = CNT_W'(trial - {1'b0, count_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.match      = match;
        stat.miss       = !match && (scan_addr_reg >= count_reg);
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CNT_W'(CAPACITY));
        stat.div_done   = (bit_cnt_reg == DRAW_CNT_W'(DRAW_W - 1));
        stat.out_free   = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.write_move)
            begin
                count_reg <= count_m1;
            end
            chk_valid_reg <= issue;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg      <= mode;
            value_reg     <= item_value;
            draw_reg      <= random_draw;
            scan_addr_reg <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            res_value_reg <= '0;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_addr_reg <= issue ? scan_addr_reg + CNT_W'(1) : scan_addr_reg;
                if (match)
                begin
                    pos_reg <= chk_addr_reg;
                end
            end
            if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                draw_reg    <= {draw_reg[DRAW_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + DRAW_CNT_W'(1);
            end
            if (cmd.capture_sample)
            begin
                res_value_reg <= rd_data_reg;
            end
        end
        chk_addr_reg <= scan_addr_reg[IDX_W-1:0];
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign sampled_value = out_value_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
    else $error("Element count exceeds capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
    else $error("Result loaded while the output word is still stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_insert |-> !stat.count_full)
    else $error("Insert written into a full store.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_move |=> count_reg == $past(count_reg) - CNT_W'(1))
    else $error("Remove did not shrink the element count.");

endmodule

`default_nettype wire

### rtl/swrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swrs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire swrs_pkg::dp_status_t stat,
    output swrs_pkg::ctrl_cmd_t       cmd
);
    import swrs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = STATUS_OK;
        in_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.mode) inside
                    MODE_INSERT, MODE_REMOVE:
                    begin
                        state_next = ST_SEARCH;
                    end
                    MODE_SAMPLE:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STATUS_EMPTY;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_DIVIDE;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        state_next     = ST_RESULT;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (stat.match)
                begin
                    if (stat.mode == MODE_INSERT)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STATUS_CONFLICT;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_RM_READ;
                    end
                end
                else if (stat.miss)
                begin
                    cmd.set_status = 1'b1;
                    state_next     = ST_RESULT;
                    if (stat.mode != MODE_INSERT)
                    begin
                        cmd.status_code = STATUS_CONFLICT;
                    end
                    else if (stat.count_full)
                    begin
                        cmd.status_code = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.write_insert = 1'b1;
                    end
                end
            end
            ST_RM_READ:
            begin
                cmd.rd_last = 1'b1;
                state_next  = ST_RM_WRITE;
            end
            ST_RM_WRITE:
            begin
                cmd.write_move = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_SAMPLE_READ;
                end
            end
            ST_SAMPLE_READ:
            begin
                cmd.rd_sample = 1'b1;
                state_next    = ST_SAMPLE_DATA;
            end
            ST_SAMPLE_DATA:
            begin
                cmd.capture_sample = 1'b1;
                cmd.set_status     = 1'b1;
                state_next         = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/set_with_random_sample.sv
// A set of distinct 32-bit signed values held densely in a 1R1W store with a count.
// Input channel (in_valid, in_stall, mode, item_value, random_draw): a word is taken when
// in_valid is high and in_stall is low. Mode: insert, remove, random sample or no-op.
// Output channel (out_valid, out_stall, status, sampled_value): one word per input word,
// in order; the block holds it steady while out_stall is high.
// Insert and remove search the store one entry per cycle; a remove that hits then reads
// the last entry and moves it into the freed slot. A sample reduces the draw by the count
// with a restoring remainder, one bit per cycle. Words are processed one at a time.
// A finished word sits in the output register, so the next input word is taken while it
// waits; a result that finds that register still stalled waits until it is freed.
// Reset empties the set and the output register; store contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module set_with_random_sample #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  mode,
    input  wire logic signed [31:0]          item_value,
    input  wire logic [swrs_pkg::DRAW_W-1:0] random_draw,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic signed [31:0]               sampled_value
);
    import swrs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    swrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    swrs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .item_value    (item_value),
        .random_draw   (random_draw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .sampled_value (sampled_value)
    );

endmodule

`default_nettype wire

### sim/set_monitor.sv
`timescale 1ns / 1ps

module set_monitor #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  swrs_pkg::mode_t               mode,
    input  logic signed [31:0]            item_value,
    input  logic [swrs_pkg::DRAW_W-1:0]   random_draw,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    status,
    input  logic signed [31:0]            sampled_value,
    output int                            errors,
    output int                            pending
);

    import swrs_pkg::*;

    typedef struct packed {
        status_t            code;
        logic signed [31:0] pick;
    } reply_t;

    logic signed [31:0] members [CAPACITY];
    int                 member_count;
    reply_t             due_replies [$];

    // Applies one word to the local copy of the set and returns the reply it should produce.
    function automatic reply_t apply_word(input mode_t op, input logic signed [31:0] value,
                                          input logic [DRAW_W-1:0] draw);
        reply_t res;
        int     slot;
        int     i;
        res.code = STATUS_OK;
        res.pick = '0;
        slot = -1;
        for (i = 0; i < member_count; i++)
        begin
            if (slot < 0 && members[i] == value)
                slot = i;
        end
        case (op)
            MODE_INSERT:
            begin
                if (slot >= 0)
                    res.code = STATUS_CONFLICT;
                else if (member_count >= CAPACITY)
                    res.code = STATUS_FULL;
                else
                begin
                    members[member_count] = value;
                    member_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (slot < 0)
                    res.code = STATUS_CONFLICT;
                else
                begin
                    members[slot] = members[member_count - 1];
                    member_count--;
                end
            end
            MODE_SAMPLE:
            begin
                if (member_count == 0)
                    res.code = STATUS_EMPTY;
                else
                    res.pick = members[int'(draw) % member_count];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            errors = 0;
            member_count = 0;
            due_replies.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_replies.size() == 0)
                begin
                    $display("%0t: unexpected word, status %0d value %0d", $time, status,
                             sampled_value);
                    errors++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (status !== want.code)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.code, status);
                        errors++;
                    end
                    if (sampled_value !== want.pick)
                    begin
                        $display("%0t: sampled value expected %0d, got %0d", $time, want.pick,
                                 sampled_value);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                due_replies.insert(due_replies.size(),
                                   apply_word(mode, item_value, random_draw));
            pending <= due_replies.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import swrs_pkg::*;

    localparam int    CAPACITY    = 64;
    localparam int    POOL_N      = 80;
    localparam int    CYCLE_LIMIT = 400000;
    localparam mode_t MODE_IDLE   = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic [DRAW_W-1:0]  DRAW_TOP = '1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    mode_t                    mode = MODE_INSERT;
    logic signed [31:0]       item_value = '0;
    logic [DRAW_W-1:0]        random_draw = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [31:0]       sampled_value;
    int                       errors;
    int                       pending;
    int                       cycles = 0;
    logic                     quiet = 1'b0;
    logic signed [31:0]       pool [POOL_N];

    set_with_random_sample #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .item_value(item_value),
        .random_draw(random_draw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .sampled_value(sampled_value)
    );

    set_monitor #(
        .CAPACITY(CAPACITY)
    ) monitor (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .item_value(item_value),
        .random_draw(random_draw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .sampled_value(sampled_value),
        .errors(errors),
        .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("set_with_random_sample: mismatch");
            $finish;
        end
    end

    task automatic send_word(input mode_t op, input logic signed [31:0] value,
                             input logic [DRAW_W-1:0] draw);
        in_valid <= 1'b1;
        mode <= op;
        item_value <= value;
        random_draw <= draw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) < 80)
            return pool[$urandom_range(0, POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return DRAW_TOP;
        return DRAW_W'($urandom_range(0, 32767));
    endfunction

    function automatic mode_t pick_mode(input logic grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < (grow ? 75 : 15))
            return MODE_INSERT;
        if (r < (grow ? 85 : 80))
            return MODE_REMOVE;
        if (r < 97)
            return MODE_SAMPLE;
        return MODE_IDLE;
    endfunction

    initial
    begin
        int round;
        int n;
        pool[0] = VAL_MIN;
        pool[1] = VAL_MAX;
        pool[2] = '0;
        pool[3] = -32'sd1;
        for (n = 4; n < POOL_N; n++)
            pool[n] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(MODE_SAMPLE, 32'sd7, 15'd5);
        send_word(MODE_REMOVE, '0, '0);
        send_word(MODE_IDLE, VAL_MIN, DRAW_TOP);
        send_word(MODE_INSERT, VAL_MIN, '0);
        send_word(MODE_INSERT, VAL_MAX, '0);
        send_word(MODE_INSERT, '0, DRAW_TOP);
        send_word(MODE_INSERT, -32'sd1, '0);
        send_word(MODE_INSERT, VAL_MIN, '0);
        send_word(MODE_SAMPLE, '0, '0);
        send_word(MODE_SAMPLE, VAL_MAX, DRAW_TOP);
        send_word(MODE_REMOVE, 32'sd12345, '0);
        send_word(MODE_REMOVE, -32'sd1, '0);
        send_word(MODE_REMOVE, VAL_MIN, '0);
        send_word(MODE_SAMPLE, '0, 15'd1);
        send_word(MODE_IDLE, VAL_MAX, DRAW_TOP);
        send_word(MODE_REMOVE, VAL_MAX, '0);
        send_word(MODE_REMOVE, '0, '0);
        send_word(MODE_SAMPLE, '0, DRAW_TOP);
        send_word(MODE_INSERT, 32'sh5555_5555, '0);
        send_word(MODE_INSERT, 32'shaaaa_aaaa, DRAW_TOP);
        send_word(MODE_SAMPLE, -32'sd1, 15'd1);
        drain();

        for (round = 0; round < 4; round++)
        begin
            quiet = (round == 2);
            for (n = 0; n < ((round % 2 == 0) ? 150 : 100); n++)
                send_word(pick_mode(round % 2 == 0), pick_value(), pick_draw());
            drain();
        end
        quiet = 1'b0;

        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("set_with_random_sample: match");
        else
            $display("set_with_random_sample: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/swrs_pkg.sv
rtl/swrs_datapath.sv
rtl/swrs_ctrl.sv
rtl/set_with_random_sample.sv
sim/set_monitor.sv
sim/tb_top.sv
